[rtl/uule_pkg.sv]
// Package for the uuencode line encoder: sizing constants, character codes,
// controller state type, shifter control struct and the 6-bit character map.
// No dependencies.
package uule_pkg;

  // Bytes in one full line; the design supports 3 to 63.
  localparam int unsigned LINE_BYTES = 45;
  localparam int unsigned CNT_W      = $clog2(LINE_BYTES + 1);
  localparam int unsigned ADDR_W     = $clog2(LINE_BYTES);
  localparam int unsigned BASE_W     = CNT_W + 1;

  localparam logic [1:0]  LAST_STEP    = 2'd3;
  localparam logic [2:0]  GROUP_BYTES  = 3'd3;
  localparam logic [6:0]  NEWLINE_CHAR = 7'd10;
  localparam logic [6:0]  ZERO_CHAR    = 7'd96;
  localparam logic [6:0]  CHAR_OFFSET  = 7'd32;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LEN,
    ST_READ,
    ST_CHARS,
    ST_NL
  } uule_state_e;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic [7:0] load_data;
  } uule_shift_ctrl_t;

  // Maps a 6-bit value to its printable character; zero becomes a backquote.
  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] c;
    c = (v == 6'd0) ? ZERO_CHAR : ({1'b0, v} + CHAR_OFFSET);
    return c;
  endfunction

endpackage

[rtl/uule_in_if.sv]
// Input channel of the uuencode line encoder: raw byte and chunk-end flag.
// Depends on nothing.
interface uule_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

[rtl/uule_out_if.sv]
// Output channel of the uuencode line encoder: one encoded character per transaction.
// Depends on nothing.
interface uule_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       line_done;

  modport source (output valid, output out_char, output line_done, input ready);
  modport sink   (input valid, input out_char, input line_done, output ready);
endinterface

[rtl/uule_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module uule_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 45,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/uule_group_shifter.sv]
// Shared group shifter: gathers three bytes into a 24-bit word and shifts out
// one encoded 6-bit character at a time. Depends on uule_pkg.
module uule_group_shifter (
  input  logic                      clk_i,
  input  uule_pkg::uule_shift_ctrl_t ctrl_i,
  output logic [6:0]                char_o
);
  import uule_pkg::*;

  logic [23:0] grp_q, grp_d;

  always_comb begin
    grp_d = grp_q;
    if (ctrl_i.load) begin
      grp_d = {grp_q[15:0], ctrl_i.load_data};
    end else if (ctrl_i.shift) begin
      grp_d = {grp_q[17:0], 6'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign char_o = enc6(grp_q[23:18]);

endmodule

[rtl/uule_line_ctrl.sv]
// Line controller: collects bytes into the line store and sequences the
// length, data and newline characters; data goes through the shared group shifter.
// Depends on uule_pkg, uule_ram and uule_group_shifter.
module uule_line_ctrl (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       out_done_o
);
  import uule_pkg::*;

  uule_state_e        state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic [1:0]         step_q, step_d;
  logic               rd_ok_q, rd_ok_d;
  logic               out_valid_q, out_valid_d;
  logic [6:0]         out_char_q, out_char_d;
  logic               out_done_q, out_done_d;

  logic               accept;
  logic               can_load;
  logic               out_load;
  logic [CNT_W-1:0]   fill_next;
  logic [BASE_W-1:0]  rd_addr;
  logic [BASE_W-1:0]  base_next;
  logic               ram_re;
  logic [7:0]         ram_rdata;
  logic [6:0]         sh_char;
  uule_shift_ctrl_t   sh_ctrl;

  assign in_ready_o = (state_q == ST_COLLECT);
  assign accept     = in_valid_i && in_ready_o;
  assign can_load   = !out_valid_q || out_ready_i;
  assign fill_next  = fill_q + CNT_W'(1);
  assign rd_addr    = base_q + BASE_W'(step_q);
  assign base_next  = base_q + BASE_W'(GROUP_BYTES);

  uule_ram #(
    .WIDTH(8),
    .DEPTH(LINE_BYTES)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(fill_q[ADDR_W-1:0]),
    .wdata_i(in_data_i),
    .re_i   (ram_re),
    .raddr_i(rd_addr[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  uule_group_shifter u_shifter (
    .clk_i (clk_i),
    .ctrl_i(sh_ctrl),
    .char_o(sh_char)
  );

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    len_d      = len_q;
    base_d     = base_q;
    step_d     = step_q;
    rd_ok_d    = rd_ok_q;
    out_load   = 1'b0;
    out_char_d = out_char_q;
    out_done_d = out_done_q;
    ram_re     = 1'b0;
    sh_ctrl    = '0;

    case (state_q)
      ST_COLLECT: begin
        if (accept) begin
          if (in_last_i || (fill_next == CNT_W'(LINE_BYTES))) begin
            len_d   = fill_next;
            fill_d  = '0;
            state_d = ST_LEN;
          end else begin
            fill_d = fill_next;
          end
        end
      end
      ST_LEN: begin
        if (can_load) begin
          out_load   = 1'b1;
          out_char_d = enc6(6'(len_q));
          out_done_d = 1'b0;
          base_d     = '0;
          step_d     = '0;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        // Steps 0..2 issue reads; steps 1..3 load the byte read in the step before.
        if (step_q != LAST_STEP) begin
          rd_ok_d = (rd_addr < BASE_W'(len_q));
          ram_re  = rd_ok_d;
        end
        if (step_q != 2'd0) begin
          sh_ctrl.load      = 1'b1;
          sh_ctrl.load_data = rd_ok_q ? ram_rdata : 8'd0;
        end
        step_d = step_q + 2'd1;
        if (step_q == LAST_STEP) begin
          state_d = ST_CHARS;
        end
      end
      ST_CHARS: begin
        if (can_load) begin
          out_load      = 1'b1;
          out_char_d    = sh_char;
          out_done_d    = 1'b0;
          sh_ctrl.shift = 1'b1;
          step_d        = step_q + 2'd1;
          if (step_q == LAST_STEP) begin
            base_d  = base_next;
            state_d = (base_next >= BASE_W'(len_q)) ? ST_NL : ST_READ;
          end
        end
      end
      ST_NL: begin
        if (can_load) begin
          out_load   = 1'b1;
          out_char_d = NEWLINE_CHAR;
          out_done_d = 1'b1;
          state_d    = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    base_q     <= base_d;
    step_q     <= step_d;
    rd_ok_q    <= rd_ok_d;
    out_char_q <= out_char_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_done_o  = out_done_q;

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CNT_W'(LINE_BYTES))
    else $error("line fill count reached the line size");

  a_chunk_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (state_q == ST_LEN))
    else $error("chunk end did not close the line");

  a_done_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> (out_char_q == NEWLINE_CHAR))
    else $error("line done flagged on a non-newline character");

  a_no_input_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHARS || state_q == ST_READ) |=> !accept)
    else $error("input accepted while a line was being encoded");
`endif

endmodule

[rtl/uuencode_line_encoder_core.sv]
// A line closes on the byte that fills it or carries chunk end; the controller then
// enters its length state, and the length character is loaded into the output register
// once that register is free or its character is taken. Bytes are taken only while a
// line is collected. Each 3-byte group is read from the line store into the shifter,
// which emits its four characters. Reset (rst_ni, asynchronous, active low) empties
// the line and the output register; the line store itself is not cleared.
module uuencode_line_encoder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  uule_in_if.sink       in_i,
  uule_out_if.source    out_o
);
  import uule_pkg::*;

  // The line controller owns the line store and the shared group
  // shifter. While a line is being emitted no input transaction is accepted;
  // the output character register lets the sink stall without losing data.
  uule_line_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_data_i  (in_i.data_byte),
    .in_last_i  (in_i.chunk_end),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_char_o (out_o.out_char),
    .out_done_o (out_o.line_done)
  );

`ifndef SYNTHESIS
  a_out_ascii_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.line_done) |-> (out_o.out_char >= 7'd32))
    else $error("non-newline output character is outside the encoded range");

  a_newline_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.out_char == NEWLINE_CHAR) |-> out_o.line_done)
    else $error("newline emitted without line done");

  a_busy_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.line_done) |-> !in_i.ready)
    else $error("input ready while line characters are still pending");
`endif

endmodule
